/* src/m2scus_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// m2scus_pkg
// Shared types and constants of the MPEG-2 start code unit splitter.
// ---------------------------------------------------------------------------
package m2scus_pkg;

	localparam logic [7:0] TYPE_PICTURE   = 8'h00;
	localparam logic [7:0] TYPE_SEQUENCE  = 8'hB3;
	localparam logic [7:0] TYPE_EXTENSION = 8'hB5;

	localparam logic [3:0] EXT_NONE           = 4'd0;
	localparam logic [3:0] EXT_SEQUENCE       = 4'd1;
	localparam logic [3:0] EXT_PICTURE_CODING = 4'd8;

	// offset of the byte that carries the extension id, from the unit start
	localparam logic [31:0] EXT_BYTE_OFFSET = 32'd4;
	// bytes in a start code prefix plus its 01 byte
	localparam logic [31:0] START_CODE_BYTES = 32'd3;

	localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

	// close event queue between scanner and descriptor stage
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] unit_offset;
		logic [23:0] unit_length;
		logic [7:0]  unit_type;
		logic        paired;
	} unit_req_t;

	// one closed unit, as seen by the scanner
	typedef struct packed {
		logic [31:0] end_pos;
		logic [31:0] start_pos;
		logic [7:0]  unit_type;
		logic [3:0]  ext_id;   // EXT_NONE unless an extension with a fifth byte
		logic        eos;      // end of stream closed it
	} close_evt_t;

endpackage

`default_nettype wire

/* src/mpeg2_start_code_unit_splitter.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mpeg2_start_code_unit_splitter
// Splits an MPEG-2 byte stream at 00 00 01 start codes into unit
// descriptors, merging sequence and picture headers with their extensions.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload      | carries
//  byte    | byte_valid / byte_stall | byte_data    | one stream byte or end of stream
//  unit    | unit_valid / unit_stall | unit_data    | one unit descriptor
//
//  One byte request is taken per cycle while byte_stall is low; the close event
//  of a unit passes from the scanner through the queue to the output register.
//  byte_stall rises only when the two-entry close event queue is full, which
//  happens only after unit_stall has held the output register.
//  Reset clears the scanner, the queue, the held header and the output valid.
// ---------------------------------------------------------------------------
module mpeg2_start_code_unit_splitter (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire m2scus_pkg::byte_req_t  byte_data,
	output logic                        unit_valid,
	input  wire logic                   unit_stall,
	output m2scus_pkg::unit_req_t       unit_data
);

	logic                   accept;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	m2scus_pkg::close_evt_t push_evt;
	m2scus_pkg::close_evt_t head_evt;

	// stall the byte channel only while the event queue has no room
	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	// front: scan bytes, track the open unit, push an event when it closes
	m2scus_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (byte_data),
		.push   (push),
		.evt    (push_evt)
	);

	// decouple scanning from descriptor output
	m2scus_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head_evt)
	);

	// back: hold headers, pair extensions, drive the descriptor register
	m2scus_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head_evt),
		.pop        (pop),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data)
	);

endmodule

`default_nettype wire

/* src/m2scus_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// m2scus_front
// Byte scanner: tracks start codes and the open unit, pushes close events.
// ---------------------------------------------------------------------------
module m2scus_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire m2scus_pkg::byte_req_t  req,
	output logic                        push,
	output m2scus_pkg::close_evt_t      evt
);

	logic [31:0] pos_q;
	logic [1:0]  zero_run_q;
	logic        await_q;
	logic        open_q;
	logic [31:0] open_start_q;
	logic [7:0]  open_type_q;
	logic [3:0]  open_ext_q;

	logic [31:0] sc_start;
	logic        at_ext_byte;

	assign sc_start    = pos_q - m2scus_pkg::START_CODE_BYTES;
	assign at_ext_byte = open_q && ((pos_q - open_start_q) == m2scus_pkg::EXT_BYTE_OFFSET);

	always_comb begin
		push          = accept && open_q && (req.end_of_stream || await_q);
		evt.end_pos   = req.end_of_stream ? pos_q : sc_start;
		evt.start_pos = open_start_q;
		evt.unit_type = open_type_q;
		evt.ext_id    = (open_type_q == m2scus_pkg::TYPE_EXTENSION) ? open_ext_q
		                                                            : m2scus_pkg::EXT_NONE;
		evt.eos       = req.end_of_stream;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			zero_run_q   <= '0;
			await_q      <= 1'b0;
			open_q       <= 1'b0;
			open_start_q <= '0;
			open_type_q  <= '0;
			open_ext_q   <= '0;
		end else if (accept) begin
			if (req.end_of_stream) begin
				// flush and restart offsets
				pos_q        <= '0;
				zero_run_q   <= '0;
				await_q      <= 1'b0;
				open_q       <= 1'b0;
				open_start_q <= '0;
				open_type_q  <= '0;
				open_ext_q   <= '0;
			end else begin
				pos_q <= pos_q + 32'd1;
				if (await_q) begin
					// type byte: open the new unit at its start code
					open_q       <= 1'b1;
					open_start_q <= sc_start;
					open_type_q  <= req.byte_value;
					open_ext_q   <= m2scus_pkg::EXT_NONE;
					await_q      <= 1'b0;
					zero_run_q   <= '0;
				end else begin
					if (at_ext_byte)
						open_ext_q <= req.byte_value[7:4];
					if (req.byte_value == 8'h00) begin
						if (zero_run_q != 2'd2)
							zero_run_q <= zero_run_q + 2'd1;
					end else begin
						if (req.byte_value == 8'h01 && zero_run_q == 2'd2)
							await_q <= 1'b1;
						zero_run_q <= '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* src/m2scus_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// m2scus_queue
// Short FIFO of close events between scanner and descriptor stage.
// ---------------------------------------------------------------------------
module m2scus_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire m2scus_pkg::close_evt_t  push_evt,
	input  wire logic                    pop,
	output logic                         full,
	output logic                         empty,
	output m2scus_pkg::close_evt_t       head
);

	m2scus_pkg::close_evt_t              mem_q [m2scus_pkg::QDEPTH];
	logic [m2scus_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [m2scus_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [m2scus_pkg::QCNT_W-1:0]       count_q;

	localparam logic [m2scus_pkg::QPTR_W-1:0] PTR_LAST =
		m2scus_pkg::QPTR_W'(m2scus_pkg::QDEPTH - 1);
	localparam logic [m2scus_pkg::QCNT_W-1:0] CNT_FULL =
		m2scus_pkg::QCNT_W'(m2scus_pkg::QDEPTH);

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("close event pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("close event popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* src/m2scus_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// m2scus_back
// Descriptor stage: holds headers, pairs extensions, registers descriptors.
// ---------------------------------------------------------------------------
module m2scus_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    empty,
	input  wire m2scus_pkg::close_evt_t  head,
	output logic                         pop,
	output logic                         unit_valid,
	input  wire logic                    unit_stall,
	output m2scus_pkg::unit_req_t        unit_data
);

	logic        held_valid_q;
	logic [31:0] held_start_q;
	logic [3:0]  held_ext_q;
	logic [7:0]  held_type_q;

	logic                  out_valid_q;
	m2scus_pkg::unit_req_t out_q;

	logic        pair;
	logic        is_header;
	logic        emit;
	logic [31:0] sel_start;
	logic [31:0] diff;
	logic [23:0] len_sat;

	assign pop = !empty && (!out_valid_q || !unit_stall);

	always_comb begin
		pair      = held_valid_q && (head.ext_id != m2scus_pkg::EXT_NONE)
		            && (head.ext_id == held_ext_q);
		is_header = (head.unit_type == m2scus_pkg::TYPE_SEQUENCE)
		            || (head.unit_type == m2scus_pkg::TYPE_PICTURE);
		emit      = pair || !is_header;
		sel_start = pair ? held_start_q : head.start_pos;
		diff      = head.end_pos - sel_start;
		len_sat   = (|diff[31:24]) ? m2scus_pkg::LEN_MAX : diff[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_start_q <= '0;
			held_ext_q   <= '0;
			held_type_q  <= '0;
		end else if (pop) begin
			if (!pair && is_header && !head.eos) begin
				// hold a header until the next unit shows whether it pairs
				held_valid_q <= 1'b1;
				held_start_q <= head.start_pos;
				held_type_q  <= head.unit_type;
				held_ext_q   <= (head.unit_type == m2scus_pkg::TYPE_SEQUENCE)
				                ? m2scus_pkg::EXT_SEQUENCE : m2scus_pkg::EXT_PICTURE_CODING;
			end else begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= emit;
		else if (!unit_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q.unit_offset <= sel_start;
			out_q.unit_length <= len_sat;
			out_q.unit_type   <= pair ? held_type_q : head.unit_type;
			out_q.paired      <= pair;
		end
	end

	assign unit_valid = out_valid_q;
	assign unit_data  = out_q;

`ifndef SYNTHESIS
	a_paired_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.paired) |->
		(out_q.unit_type == m2scus_pkg::TYPE_SEQUENCE
		 || out_q.unit_type == m2scus_pkg::TYPE_PICTURE))
		else $error("paired descriptor without header type");
	a_unpaired_not_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.paired) |->
		(out_q.unit_type != m2scus_pkg::TYPE_SEQUENCE
		 && out_q.unit_type != m2scus_pkg::TYPE_PICTURE))
		else $error("header emitted without its extension");
	a_eos_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.eos) |=> !held_valid_q)
		else $error("held header survived end of stream");
`endif

endmodule

`default_nettype wire

/* dv/mpeg2_start_code_unit_splitter_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpeg2_start_code_unit_splitter_tb
// Drives byte streams into the start code unit splitter, predicts every unit
// descriptor in a scanner of its own and checks each descriptor field by
// field, with random idling on both channels and long output hold-offs.
// ---------------------------------------------------------------------------
module mpeg2_start_code_unit_splitter_tb;

	// start code prefix bytes
	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE  = 8'h01;

	localparam int STREAM_BYTES = 1650;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	m2scus_pkg::byte_req_t byte_data  = '0;
	logic                  unit_valid;
	logic                  unit_stall = 1'b0;
	m2scus_pkg::unit_req_t unit_data;

	// byte requests waiting to be offered, descriptors waiting to arrive
	m2scus_pkg::byte_req_t byte_backlog[$];
	m2scus_pkg::unit_req_t pending_units[$];
	int unsigned           stream_total;

	// scanner state of the predictor
	logic [31:0] scan_pos;
	logic [1:0]  zero_count;
	logic        want_type;
	logic        unit_is_open;
	logic [31:0] open_start;
	logic [7:0]  open_type;
	logic [3:0]  open_ext;
	logic        held_valid;
	logic [31:0] held_start;
	logic [3:0]  held_ext;
	logic [7:0]  held_type;

	int unsigned bytes_taken     = 0;
	int unsigned eos_taken       = 0;
	int unsigned units_checked   = 0;
	int unsigned paired_expected = 0;
	int unsigned mismatches      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned byte_gap        = 0;
	int unsigned hold_left       = 0;
	int unsigned long_holds      = 0;

	mpeg2_start_code_unit_splitter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Predictor: a byte-level scanner that closes units and pairs headers
	// -----------------------------------------------------------------------

	task automatic clear_scanner();
		scan_pos     = '0;
		zero_count   = '0;
		want_type    = 1'b0;
		unit_is_open = 1'b0;
		open_start   = '0;
		open_type    = '0;
		open_ext     = m2scus_pkg::EXT_NONE;
		held_valid   = 1'b0;
		held_start   = '0;
		held_ext     = m2scus_pkg::EXT_NONE;
		held_type    = '0;
	endtask

	// offset difference modulo 2^32, clamped to the 24-bit length field
	function automatic logic [23:0] clamp_len(input logic [31:0] stop,
			input logic [31:0] first);
		logic [31:0] span;
		span = stop - first;
		return (span > {8'h00, m2scus_pkg::LEN_MAX}) ? m2scus_pkg::LEN_MAX : span[23:0];
	endfunction

	// Close the open unit at stop: pair with a held header, hold a new
	// header, or emit the unit alone.
	task automatic close_unit(input logic [31:0] stop);
		logic [3:0]            ext;
		m2scus_pkg::unit_req_t desc;
		ext = (open_type == m2scus_pkg::TYPE_EXTENSION) ? open_ext : m2scus_pkg::EXT_NONE;
		if (held_valid) begin
			held_valid = 1'b0;
			if (ext != m2scus_pkg::EXT_NONE && ext == held_ext) begin
				desc.unit_offset = held_start;
				desc.unit_length = clamp_len(stop, held_start);
				desc.unit_type   = held_type;
				desc.paired      = 1'b1;
				pending_units.push_back(desc);
				paired_expected++;
				return;
			end
		end
		if (open_type == m2scus_pkg::TYPE_SEQUENCE || open_type == m2scus_pkg::TYPE_PICTURE) begin
			held_valid = 1'b1;
			held_start = open_start;
			held_type  = open_type;
			held_ext   = (open_type == m2scus_pkg::TYPE_SEQUENCE)
			             ? m2scus_pkg::EXT_SEQUENCE : m2scus_pkg::EXT_PICTURE_CODING;
			return;
		end
		desc.unit_offset = open_start;
		desc.unit_length = clamp_len(stop, open_start);
		desc.unit_type   = open_type;
		desc.paired      = 1'b0;
		pending_units.push_back(desc);
	endtask

	task automatic scan_byte(input m2scus_pkg::byte_req_t req);
		logic [31:0] sc_start;
		if (req.end_of_stream) begin
			eos_taken++;
			if (unit_is_open)
				close_unit(scan_pos);
			clear_scanner();
			return;
		end
		if (want_type) begin
			// the type byte never counts toward a new prefix
			sc_start = scan_pos - m2scus_pkg::START_CODE_BYTES;
			if (unit_is_open)
				close_unit(sc_start);
			unit_is_open = 1'b1;
			open_start   = sc_start;
			open_type    = req.byte_value;
			open_ext     = m2scus_pkg::EXT_NONE;
			want_type    = 1'b0;
			zero_count   = '0;
		end else begin
			if (unit_is_open && scan_pos - open_start == m2scus_pkg::EXT_BYTE_OFFSET)
				open_ext = req.byte_value[7:4];
			if (req.byte_value == SC_ZERO) begin
				if (zero_count < 2'd2)
					zero_count++;
			end else begin
				if (req.byte_value == SC_ONE && zero_count >= 2'd2)
					want_type = 1'b1;
				zero_count = '0;
			end
		end
		scan_pos++;
	endtask

	// -----------------------------------------------------------------------
	// Stimulus building
	// -----------------------------------------------------------------------

	task automatic push_byte(input logic [7:0] value);
		m2scus_pkg::byte_req_t req;
		req.byte_value    = value;
		req.end_of_stream = 1'b0;
		byte_backlog.push_back(req);
	endtask

	// the byte value rides along but is ignored by the block
	task automatic push_eos(input logic [7:0] value);
		m2scus_pkg::byte_req_t req;
		req.byte_value    = value;
		req.end_of_stream = 1'b1;
		byte_backlog.push_back(req);
	endtask

	task automatic push_start_code(input logic [7:0] kind);
		push_byte(SC_ZERO);
		push_byte(SC_ZERO);
		push_byte(SC_ONE);
		push_byte(kind);
	endtask

	// payload byte, with enough zeros and ones to form stray prefixes now and then
	function automatic logic [7:0] body_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return SC_ZERO;
		if (r < 12)
			return SC_ONE;
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly short units, a few longer ones
	function automatic int unsigned body_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 10);
		return $urandom_range(11, 60);
	endfunction

	// an empty body leaves an extension too short to carry an id
	function automatic int unsigned ext_len();
		if ($urandom_range(0, 99) < 8)
			return 0;
		return $urandom_range(1, 10);
	endfunction

	function automatic logic [3:0] ext_id_for(input logic [3:0] wanted);
		if ($urandom_range(0, 9) < 8)
			return wanted;
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic push_unit(input logic [7:0] kind, input logic [3:0] ext_id,
			input int unsigned len);
		// an extra zero before the prefix stays in the previous unit
		if ($urandom_range(0, 9) == 0)
			push_byte(SC_ZERO);
		push_start_code(kind);
		for (int i = 0; i < len; i++) begin
			if (i == 0 && kind == m2scus_pkg::TYPE_EXTENSION)
				push_byte({ext_id, 4'($urandom_range(0, 15))});
			else
				push_byte(body_byte());
		end
	endtask

	// one stream: junk, a run of units with headers mostly followed by
	// their extensions, an occasional broken tail, then end of stream
	task automatic push_stream();
		int unsigned n;
		int unsigned k;
		int unsigned r;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom_range(0, 255)));
		n = $urandom_range(1, 12);
		for (int u = 0; u < n; u++) begin
			k = $urandom_range(0, 99);
			if (k < 22) begin
				push_unit(m2scus_pkg::TYPE_SEQUENCE, m2scus_pkg::EXT_NONE, body_len());
				if ($urandom_range(0, 9) < 7)
					push_unit(m2scus_pkg::TYPE_EXTENSION,
						ext_id_for(m2scus_pkg::EXT_SEQUENCE), ext_len());
			end else if (k < 44) begin
				push_unit(m2scus_pkg::TYPE_PICTURE, m2scus_pkg::EXT_NONE, body_len());
				if ($urandom_range(0, 9) < 7)
					push_unit(m2scus_pkg::TYPE_EXTENSION,
						ext_id_for(m2scus_pkg::EXT_PICTURE_CODING), ext_len());
			end else if (k < 54) begin
				push_unit(m2scus_pkg::TYPE_EXTENSION, 4'($urandom_range(0, 15)), ext_len());
			end else begin
				push_unit(8'($urandom_range(0, 255)), m2scus_pkg::EXT_NONE, body_len());
			end
		end
		k = $urandom_range(0, 99);
		if (k < 10) begin
			// prefix left without its type byte
			push_byte(SC_ZERO);
			push_byte(SC_ZERO);
			push_byte(SC_ONE);
		end else if (k < 20) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				push_byte(r < 40 ? SC_ZERO : (r < 60 ? SC_ONE : 8'($urandom_range(0, 255))));
			end
		end
		push_eos(8'($urandom_range(0, 255)));
	endtask

	// -----------------------------------------------------------------------
	// Byte side driver
	// -----------------------------------------------------------------------

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		// back-to-back stretch every few hundred bytes
		if ((bytes_taken % 400) < 100)
			return 0;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data  <= '0;
			byte_gap   <= 0;
			clear_scanner();
		end else begin
			// predict from each request the block takes
			if (byte_valid && !byte_stall) begin
				scan_byte(byte_data);
				bytes_taken++;
			end
			// hold a stalled request; otherwise idle out the gap or advance
			if (!byte_valid || !byte_stall) begin
				if (byte_gap != 0) begin
					byte_valid <= 1'b0;
					byte_gap   <= byte_gap - 1;
				end else if (byte_backlog.size() != 0) begin
					byte_valid <= 1'b1;
					byte_data  <= byte_backlog.pop_front();
					byte_gap   <= pick_gap();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Unit side monitor and stall generator
	// -----------------------------------------------------------------------

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH descriptor %0d %s: got %0h, want %0h", units_checked, field, got,
			want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		m2scus_pkg::unit_req_t want;
		if (!arst_n) begin
			unit_stall <= 1'b0;
			hold_left  <= 0;
		end else begin
			if (unit_valid && !unit_stall) begin
				if (pending_units.size() == 0) begin
					report_mismatch("arrived with none expected", unit_data.unit_offset, '0);
				end else begin
					want = pending_units.pop_front();
					if (unit_data.unit_offset !== want.unit_offset)
						report_mismatch("unit_offset", unit_data.unit_offset, want.unit_offset);
					if (unit_data.unit_length !== want.unit_length)
						report_mismatch("unit_length", 32'(unit_data.unit_length),
							32'(want.unit_length));
					if (unit_data.unit_type !== want.unit_type)
						report_mismatch("unit_type", 32'(unit_data.unit_type),
							32'(want.unit_type));
					if (unit_data.paired !== want.paired)
						report_mismatch("paired", 32'(unit_data.paired), 32'(want.paired));
				end
				units_checked++;
			end
			// long hold-offs fill the close event queue and back up the byte side
			if (hold_left != 0) begin
				unit_stall <= 1'b1;
				hold_left  <= hold_left - 1;
			end else if ((long_holds == 0 && units_checked >= 20)
					|| (long_holds == 1 && units_checked >= 100)) begin
				unit_stall <= 1'b1;
				hold_left  <= LONG_HOLD;
				long_holds++;
			end else if ((units_checked % 40) < 10) begin
				unit_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:54]: begin
						unit_stall <= 1'b0;
					end
					[55:89]: begin
						unit_stall <= 1'b1;
						hold_left  <= $urandom_range(0, 3);
					end
					default: begin
						unit_stall <= 1'b1;
						hold_left  <= $urandom_range(10, 30);
					end
				endcase
			end
		end
	end

	// -----------------------------------------------------------------------
	// Watchdog: end the run when no request moves for too long
	// -----------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("mpeg2_start_code_unit_splitter_tb: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus and end of run
	// -----------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;

		// sequence header paired with its extension, then a picture header
		// dropped unemitted when the stream ends; the extra zero saturates the run
		push_byte(SC_ZERO);
		push_start_code(m2scus_pkg::TYPE_SEQUENCE);
		push_start_code(m2scus_pkg::TYPE_EXTENSION);
		push_byte({m2scus_pkg::EXT_SEQUENCE, 4'hF});
		push_start_code(m2scus_pkg::TYPE_PICTURE);
		push_eos(8'hFF);
		// junk before the first prefix, a header replacing a held header,
		// and an extension too short to carry an id
		push_byte(8'hFF);
		push_start_code(m2scus_pkg::TYPE_PICTURE);
		push_start_code(m2scus_pkg::TYPE_SEQUENCE);
		push_start_code(m2scus_pkg::TYPE_EXTENSION);
		push_eos(SC_ZERO);

		while (byte_backlog.size() < STREAM_BYTES)
			push_stream();
		stream_total = byte_backlog.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: every request taken and every descriptor seen before the end
		while (bytes_taken != stream_total)
			@(posedge clk);
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d byte requests in %0d streams", bytes_taken, eos_taken);
		$display("checked %0d unit descriptors, %0d of them header/extension pairs",
			units_checked, paired_expected);
		if (mismatches == 0 && pending_units.size() == 0)
			$display("mpeg2_start_code_unit_splitter_tb: done, clean");
		else
			$display("mpeg2_start_code_unit_splitter_tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
src/m2scus_pkg.sv
src/m2scus_front.sv
src/m2scus_queue.sv
src/m2scus_back.sv
src/mpeg2_start_code_unit_splitter.sv
dv/mpeg2_start_code_unit_splitter_tb.sv
